>>> hw/rtl/balsm_pkg.sv
// Package for the byte-addressed load/store memory unit.
// Holds operation codes, access sizes, the front-to-back item type and lane mapping.
// No dependencies.
package balsm_pkg;

  localparam logic [2:0] FN_LB  = 3'd0;
  localparam logic [2:0] FN_LBU = 3'd1;
  localparam logic [2:0] FN_LH  = 3'd2;
  localparam logic [2:0] FN_LHU = 3'd3;
  localparam logic [2:0] FN_LW  = 3'd4;
  localparam logic [2:0] FN_SB  = 3'd5;
  localparam logic [2:0] FN_SH  = 3'd6;
  localparam logic [2:0] FN_SW  = 3'd7;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam logic REG_BIG_ENDIAN = 1'b0;

  localparam int DEF_MEM_WORDS = 4096;
  localparam int QDEPTH        = 2;

  typedef struct packed {
    logic        is_load;
    logic        sext;
    logic [1:0]  sz;
    logic        fault;
    logic [1:0]  addr_lo;
    logic        big_endian;
    logic [29:0] widx;
    logic [3:0]  wen;
    logic [31:0] wdata;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // {hit, pos}: whether RAM lane k belongs to the access, and which
  // byte of the value it carries.
  function automatic logic [2:0] lane_map(input logic [1:0] lane, input logic [1:0] addr_lo,
                                          input logic [1:0] sz, input logic be);
    logic [1:0] i;
    logic [2:0] n;
    logic       hit;
    logic [1:0] pos;
    i   = lane - addr_lo;
    n   = 3'd1 << sz;
    hit = ({1'b0, i} < n) && (lane >= addr_lo);
    pos = be ? 2'(n - 3'd1 - {1'b0, i}) : i;
    return {hit, pos};
  endfunction

endpackage

>>> hw/rtl/balsm_front.sv
// Front end: accepts load/store beats, forms the effective address, checks
// range and alignment, and steers store bytes onto RAM lanes. Uses balsm_pkg.
module balsm_front #(
  parameter int MEM_WORDS = balsm_pkg::DEF_MEM_WORDS
) (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2:0]            in_func,
  input  logic [31:0]           in_base,
  input  logic [15:0]           in_offset,
  input  logic [31:0]           in_store_data,
  input  logic                  big_endian,
  input  balsm_pkg::qstat_t     qstat,
  output logic                  q_push,
  output balsm_pkg::item_t      q_item
);

  localparam int unsigned MEM_BYTES = MEM_WORDS * 4;

  logic [31:0] addr;
  logic [1:0]  sz;
  logic        is_load;
  logic        sext;
  logic        misal;
  logic        fault;
  logic [2:0]  lm [4];

  assign addr = in_base + {{16{in_offset[15]}}, in_offset};

  always_comb begin
    case (in_func) inside
      balsm_pkg::FN_LB, balsm_pkg::FN_LBU, balsm_pkg::FN_SB: sz = balsm_pkg::SZ_BYTE;
      balsm_pkg::FN_LH, balsm_pkg::FN_LHU, balsm_pkg::FN_SH: sz = balsm_pkg::SZ_HALF;
      default: sz = balsm_pkg::SZ_WORD;
    endcase
  end

  assign is_load = (in_func == balsm_pkg::FN_LB) || (in_func == balsm_pkg::FN_LBU) ||
                   (in_func == balsm_pkg::FN_LH) || (in_func == balsm_pkg::FN_LHU) ||
                   (in_func == balsm_pkg::FN_LW);
  assign sext    = (in_func == balsm_pkg::FN_LB) || (in_func == balsm_pkg::FN_LH);
  assign misal   = ((sz == balsm_pkg::SZ_HALF) && addr[0]) ||
                   ((sz == balsm_pkg::SZ_WORD) && (addr[1:0] != 2'd0));
  assign fault   = (addr >= 32'(MEM_BYTES)) || misal;

  always_comb begin
    q_item            = '0;
    q_item.is_load    = is_load;
    q_item.sext       = sext;
    q_item.sz         = sz;
    q_item.fault      = fault;
    q_item.addr_lo    = addr[1:0];
    q_item.big_endian = big_endian;
    q_item.widx       = addr[31:2];
    for (int k = 0; k < 4; k++) begin
      lm[k] = balsm_pkg::lane_map(2'(k), addr[1:0], sz, big_endian);
      q_item.wen[k] = lm[k][2] && !is_load && !fault;
      q_item.wdata[k*8 +: 8] = in_store_data[{lm[k][1:0], 3'b000} +: 8];
    end
  end

  assign in_tready = !qstat.full;
  assign q_push    = in_tvalid && in_tready;

endmodule

>>> hw/rtl/balsm_queue.sv
// Short FIFO that decouples the front end from the RAM back end.
// Uses balsm_pkg for the item type and depth.
module balsm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  balsm_pkg::item_t   push_item,
  input  logic               pop,
  output balsm_pkg::item_t   pop_item,
  output balsm_pkg::qstat_t  qstat
);

  localparam int QAW = (balsm_pkg::QDEPTH > 1) ? $clog2(balsm_pkg::QDEPTH) : 1;

  balsm_pkg::item_t   slot_r [balsm_pkg::QDEPTH];
  logic [QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]       count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(balsm_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(balsm_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item    = slot_r[rd_ptr_r];
  assign qstat.full  = (count_r == (QAW+1)'(balsm_pkg::QDEPTH));
  assign qstat.empty = (count_r == '0);

endmodule

>>> hw/rtl/balsm_back.sv
// Back end: four byte-lane RAM banks, read-then-format sequence and the result register.
// Uses balsm_pkg for the item type, size codes and lane mapping.
module balsm_back #(
  parameter int MEM_WORDS = balsm_pkg::DEF_MEM_WORDS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  balsm_pkg::item_t   q_item,
  input  balsm_pkg::qstat_t  qstat,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_load_data,
  output logic               out_fault
);

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  logic              pend_r;
  balsm_pkg::item_t  pend_item_r;
  logic [7:0]        rd_r [4];
  logic              out_valid_r;
  logic [31:0]       out_data_r, out_data_nxt;
  logic              out_fault_r;
  logic [2:0]        lm [4];
  logic [31:0]       raw;

  assign pop = !qstat.empty && !pend_r && (!out_valid_r || out_tready);

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0] bank_mem_r [MEM_WORDS];
    always_ff @(posedge clk) begin
      if (pop) begin
        if (q_item.wen[k]) begin
          bank_mem_r[q_item.widx[AW-1:0]] <= q_item.wdata[k*8 +: 8];
        end
        rd_r[k] <= bank_mem_r[q_item.widx[AW-1:0]];
      end
    end
  end

  always_comb begin
    raw = '0;
    for (int k = 0; k < 4; k++) begin
      lm[k] = balsm_pkg::lane_map(2'(k), pend_item_r.addr_lo, pend_item_r.sz,
                                  pend_item_r.big_endian);
      if (lm[k][2]) begin
        raw = raw | (32'(rd_r[k]) << {lm[k][1:0], 3'b000});
      end
    end
    out_data_nxt = raw;
    if (pend_item_r.sext && (pend_item_r.sz == balsm_pkg::SZ_BYTE) && raw[7]) begin
      out_data_nxt = raw | 32'hFFFF_FF00;
    end else if (pend_item_r.sext && (pend_item_r.sz == balsm_pkg::SZ_HALF) && raw[15]) begin
      out_data_nxt = raw | 32'hFFFF_0000;
    end
    if (!pend_item_r.is_load || pend_item_r.fault) begin
      out_data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pop;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pend_item_r <= q_item;
    end
    if (pend_r) begin
      out_data_r  <= out_data_nxt;
      out_fault_r <= pend_item_r.fault;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_load_data = out_data_r;
  assign out_fault     = out_fault_r;

endmodule

>>> hw/rtl/byte_addressed_load_store_memory_unit.sv
// Top level of the byte-addressed MIPS load/store data memory.
// Instantiates balsm_front, balsm_queue and balsm_back; uses balsm_pkg.
//
//  channel  direction  tdata / data                                   tuser
//  in_      slave      [31:0] base_address, [47:32] address_offset,   [2:0] func
//                      [79:48] store_data
//  out_     master     [31:0] load_data                               [0] fault
//  cfg_     APB        reg 0 at 0x0: [0] big_endian (reset 1)         -
//
// An accepted beat leaves the queue in the next cycle at the earliest. The RAM read (or
// write) happens at that pop edge; the formatted result is registered in the next cycle,
// and out_tvalid rises with it. The back end holds one item at a time, so it pops no new
// item until the last one is formatted and the output register is free or being taken.
// Reset clears control state only; RAM contents are undefined until written.
// A two-entry queue lets the front end keep accepting while a result is stalled;
// in_tready drops once both entries are taken.
module byte_addressed_load_store_memory_unit #(
  parameter int MEM_WORDS = balsm_pkg::DEF_MEM_WORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // base_address, address_offset, store_data
  input  logic [2:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // load_data
  output logic        out_tuser,  // fault
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic               big_endian_r;
  logic               cfg_wr;
  logic               q_push;
  logic               q_pop;
  balsm_pkg::item_t   push_item;
  balsm_pkg::item_t   pop_item;
  balsm_pkg::qstat_t  qstat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b1;
    end else if (cfg_wr && (cfg_paddr[2] == balsm_pkg::REG_BIG_ENDIAN)) begin
      big_endian_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == balsm_pkg::REG_BIG_ENDIAN) ?
                      {31'd0, big_endian_r} : 32'd0;

  balsm_front #(.MEM_WORDS(MEM_WORDS)) u_front (
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_func       (in_tuser),
    .in_base       (in_tdata[31:0]),
    .in_offset     (in_tdata[47:32]),
    .in_store_data (in_tdata[79:48]),
    .big_endian    (big_endian_r),
    .qstat         (qstat),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  balsm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  balsm_back #(.MEM_WORDS(MEM_WORDS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_item        (pop_item),
    .qstat         (qstat),
    .pop           (q_pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_load_data (out_tdata),
    .out_fault     (out_tuser)
  );

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 32'd0))
    else $error("faulting result carries nonzero load data");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !qstat.empty)
    else $error("pop from empty queue");

  a_push_notfull: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !qstat.full)
    else $error("push into full queue");

endmodule

>>> bench/lsu_scoreboard_pkg.sv
// Scoreboard for the byte-addressed load/store memory unit bench: tracks the byte
// image, the byte order and the queue of expected load results.
// Depends on balsm_pkg for operation codes and the memory size.
package lsu_scoreboard_pkg;
  import balsm_pkg::*;

  localparam int MEM_BYTES = DEF_MEM_WORDS * 4;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] base;
    logic [15:0] offs;
    logic [31:0] data;
  } lsu_req_t;

  typedef struct packed {
    logic [31:0] load_data;
    logic        fault;
  } lsu_result_t;

  class lsu_scoreboard;
    logic [7:0]  mem_bytes [MEM_BYTES];
    bit          written [MEM_BYTES];
    bit          big_endian;
    lsu_result_t expected_q [$];
    int          errors;

    function new();
      big_endian = 1'b1;
      errors = 0;
    endfunction

    function logic [31:0] eff_addr(logic [31:0] base, logic [15:0] offs);
      return base + {{16{offs[15]}}, offs};
    endfunction

    function int unsigned access_size(logic [2:0] func);
      case (func)
        FN_LB, FN_LBU, FN_SB: return 1;
        FN_LH, FN_LHU, FN_SH: return 2;
        default: return 4;
      endcase
    endfunction

    function bit is_fault(logic [31:0] addr, int unsigned n);
      return (addr >= MEM_BYTES) || ((addr & (n - 1)) != 0);
    endfunction

    // True unless the access is a load that would touch a never-written byte.
    function bit load_safe(logic [2:0] func, logic [31:0] base, logic [15:0] offs);
      logic [31:0] addr;
      int unsigned n;
      addr = eff_addr(base, offs);
      n = access_size(func);
      if (func >= FN_SB || is_fault(addr, n)) return 1'b1;
      for (int unsigned i = 0; i < n; i++) begin
        if (!written[addr + i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_access(logic [2:0] func, logic [31:0] base, logic [15:0] offs,
                              logic [31:0] data);
      logic [31:0] addr;
      logic [31:0] val;
      int unsigned n;
      int unsigned pos;
      lsu_result_t res;
      addr = eff_addr(base, offs);
      n = access_size(func);
      res.load_data = '0;
      res.fault = is_fault(addr, n);
      if (!res.fault) begin
        if (func < FN_SB) begin
          val = '0;
          for (int unsigned i = 0; i < n; i++) begin
            pos = big_endian ? n - 1 - i : i;
            val |= {24'b0, mem_bytes[addr + i]} << (8 * pos);
          end
          case (func)
            FN_LB: val = {{24{val[7]}}, val[7:0]};
            FN_LH: val = {{16{val[15]}}, val[15:0]};
            default: ;
          endcase
          res.load_data = val;
        end else begin
          for (int unsigned i = 0; i < n; i++) begin
            pos = big_endian ? n - 1 - i : i;
            mem_bytes[addr + i] = 8'(data >> (8 * pos));
            written[addr + i] = 1'b1;
          end
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [31:0] load_data, logic fault);
      lsu_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: load_data %h fault %0b", load_data, fault);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (load_data !== exp_res.load_data) begin
        $error("load_data: expected %h, actual %h", exp_res.load_data, load_data);
        errors++;
      end
      if (fault !== exp_res.fault) begin
        $error("fault: expected %0b, actual %0b", exp_res.fault, fault);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> bench/tb_byte_addressed_load_store_memory_unit.sv
// Testbench for byte_addressed_load_store_memory_unit: directed and random loads and
// stores under both byte orders, with random idling, back-pressure and a stall watchdog.
// Depends on balsm_pkg and lsu_scoreboard_pkg.
module tb_byte_addressed_load_store_memory_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import balsm_pkg::*;
  import lsu_scoreboard_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam logic [2:0] CFG_ENDIAN_ADDR = {REG_BIG_ENDIAN, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // base_address, address_offset, store_data
  logic [2:0]  in_tuser;   // func
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // load_data
  logic        out_tuser;  // fault
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lsu_scoreboard sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int quiet_cycles;

  byte_addressed_load_store_memory_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_access(in_tuser, in_tdata[31:0], in_tdata[47:32], in_tdata[79:48]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser);
  end

  // result side: random stalls, plus a long hold-off when requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_byte_addressed_load_store_memory_unit: FAIL");
    $finish;
  end

  function automatic lsu_req_t req(logic [2:0] func, logic [31:0] base, logic [15:0] offs,
                                   logic [31:0] data);
    lsu_req_t r;
    r.func = func;
    r.base = base;
    r.offs = offs;
    r.data = data;
    return r;
  endfunction

  task automatic send(input lsu_req_t r);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.func;
    in_tdata  <= {r.data, r.offs, r.base};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(negedge clk) in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_endian(input logic value);
    logic [31:0] rd;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ENDIAN_ADDR;
    cfg_pwdata  <= {31'b0, value};
    @(negedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.big_endian = value;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[0] !== value) begin
      $error("big_endian: expected %0b, actual %0b", value, rd[0]);
      sb.errors++;
    end
  endtask

  // Mostly aligned accesses near the bottom of memory so loads hit stored bytes;
  // the rest lands near the top edge, anywhere, or far out of range.
  task automatic make_item(output lsu_req_t r);
    int unsigned sel;
    int unsigned n;
    logic [31:0] addr;
    r.func = 3'($urandom_range(7));
    r.offs = 16'($urandom);
    r.data = $urandom;
    n = sb.access_size(r.func);
    sel = $urandom_range(99);
    if (sel < 10) begin
      addr = $urandom;
    end else begin
      if (sel < 18)
        addr = MEM_BYTES - 8 + $urandom_range(15);
      else if (sel < 25)
        addr = $urandom_range(MEM_BYTES - 1);
      else
        addr = $urandom_range(63);
      if ($urandom_range(99) < 85) addr = addr & ~(n - 1);
    end
    r.base = addr - {{16{r.offs[15]}}, r.offs};
    if (!sb.load_safe(r.func, r.base, r.offs))
      r.func = (n == 1) ? FN_SB : (n == 2) ? FN_SH : FN_SW;
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count,
                           input int hold);
    lsu_req_t r;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    hold_left = hold;
    repeat (count) begin
      make_item(r);
      send(r);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // big endian after reset
    send(req(FN_SW,  32'h0,         16'h0,    32'h80FF_7F01));
    send(req(FN_LW,  32'h0,         16'h0,    32'h0));
    send(req(FN_LB,  32'h0,         16'h0,    32'h0));
    send(req(FN_LBU, 32'h0,         16'h0,    32'h0));
    send(req(FN_LB,  32'h3,         16'h0,    32'h0));
    send(req(FN_LH,  32'h0,         16'h0,    32'h0));
    send(req(FN_LHU, 32'h2,         16'h0,    32'h0));
    send(req(FN_SB,  32'h4,         16'h0,    32'h1234_56AB));
    send(req(FN_SH,  32'h6,         16'h0,    32'hFFFF_8001));
    send(req(FN_LBU, 32'h4,         16'h0,    32'h0));
    send(req(FN_LH,  32'h6,         16'h0,    32'h0));
    send(req(FN_SW,  32'h2,         16'h0,    32'hDEAD_BEEF));  // misaligned, no write
    send(req(FN_LW,  32'h0,         16'h0,    32'h0));
    send(req(FN_LH,  32'h1,         16'h0,    32'h0));
    send(req(FN_LHU, 32'h3,         16'h0,    32'h0));
    send(req(FN_SW,  32'h0000_4000, 16'hFFFC, 32'hFFFF_FFFF));  // last word
    send(req(FN_LW,  32'h0000_4000, 16'hFFFC, 32'h0));
    send(req(FN_LW,  32'h0000_4000, 16'h0,    32'h0));          // just past the end
    send(req(FN_LW,  32'hFFFF_FFF8, 16'h0008, 32'h0));          // wraps to 0
    send(req(FN_LB,  32'h0,         16'hFFFF, 32'h0));
    send(req(FN_LBU, 32'h7FFF_FFFF, 16'h7FFF, 32'h0));
    send(req(FN_SB,  32'hFFFF_FFFF, 16'h8000, 32'hFFFF_FFFF));
    send(req(FN_SH,  32'h0000_4000, 16'h0002, 32'h1234_5678));
    send(req(FN_LB,  32'h0000_3FFF, 16'h0,    32'h0));
    drain();

    write_endian(1'b0);
    run_phase(0, 0, 80, 0);
    write_endian(1'b1);
    run_phase(78, 0, 80, 0);
    write_endian(1'b0);
    run_phase(0, 78, 80, 0);
    write_endian(1'b1);
    run_phase(29, 29, 80, 0);
    write_endian(1'b0);
    run_phase(0, 0, 80, 60);

    if (sb.errors == 0)
      $display("tb_byte_addressed_load_store_memory_unit: PASS");
    else
      $display("tb_byte_addressed_load_store_memory_unit: FAIL");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/balsm_pkg.sv
hw/rtl/balsm_front.sv
hw/rtl/balsm_queue.sv
hw/rtl/balsm_back.sv
hw/rtl/byte_addressed_load_store_memory_unit.sv
bench/lsu_scoreboard_pkg.sv
bench/tb_byte_addressed_load_store_memory_unit.sv
